/* rtl/assert_macros.svh */
// Assertion macros for the page store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PSFL_ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error(msg);

// Concurrent assertion on the block clock clk and reset rst_n.
`define PSFL_ASSERT(lbl, prop, msg) `PSFL_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

/* rtl/psfl_pkg.sv */
// Package with the types, codes and sizes of the page store with free-page stack.
package psfl_pkg;

    // Store geometry.
    localparam int NUM_PAGES   = 256;
    localparam int PAGE_WORDS  = 32;
    localparam int MAX_OUT     = 32;
    localparam int MAX_WORDS   = (PAGE_WORDS < MAX_OUT) ? PAGE_WORDS : MAX_OUT;
    localparam int PAGE_BYTES  = PAGE_WORDS * 8;

    // Field widths.
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int PAGE_ID_W   = 8;
    localparam int WIDX_W      = 5;
    localparam int LEN_W       = 9;
    localparam int WORD_W      = 64;

    // Derived widths.
    localparam int WORD_IDX_W  = $clog2(PAGE_WORDS);
    localparam int DATA_AW     = PAGE_ID_W + WORD_IDX_W;
    localparam int DATA_DEPTH  = NUM_PAGES * PAGE_WORDS;
    localparam int CNT_W       = $clog2(NUM_PAGES + 1);
    localparam int NW_W        = $clog2(MAX_WORDS + 1);

    // Stream packing.
    localparam int IN_FIELDS_W  = PAGE_ID_W + WIDX_W + LEN_W + WORD_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W    = ((REQ_W + 1 + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = PAGE_ID_W + LEN_W + WORD_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;
    localparam int OUT_USER_W   = ((STATUS_W + 7) / 8) * 8;

    localparam int WIDX_OFS     = PAGE_ID_W;
    localparam int CNT_OFS      = WIDX_OFS + WIDX_W;
    localparam int DW_OFS       = CNT_OFS + LEN_W;

    // Request codes.
    typedef logic [REQ_W-1:0] req_code_t;
    localparam req_code_t REQ_STORE  = 2'd0;
    localparam req_code_t REQ_LOAD   = 2'd1;
    localparam req_code_t REQ_DELETE = 2'd2;
    localparam req_code_t REQ_NONE   = 2'd3;

    // Result status codes.
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_BAD_PAGE = 2'd1;
    localparam status_t STAT_NO_FREE  = 2'd2;
    localparam status_t STAT_TOO_LONG = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    // One request item.
    typedef struct packed {
        req_code_t             req;
        logic                  new_page;
        logic [PAGE_ID_W-1:0]  page;
        logic [WIDX_W-1:0]     word_index;
        logic [LEN_W-1:0]      byte_count;
        logic [WORD_W-1:0]     data_word;
    } item_t;

    // One result item.
    typedef struct packed {
        status_t               status;
        logic [PAGE_ID_W-1:0]  page;
        logic [LEN_W-1:0]      len;
        logic [WORD_W-1:0]     data;
        logic                  last;
    } result_t;

    // Per-page metadata: byte length and a mask of words written since the store began.
    typedef struct packed {
        logic [LEN_W-1:0]      len;
        logic [PAGE_WORDS-1:0] written;
    } meta_t;

    localparam int META_W = $bits(meta_t);

endpackage

/* rtl/psfl_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module psfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/page_store_free_list.sv */
// Top level of the page store with a last-in first-out stack of freed page ids.
//
//  Channel  | Direction | Carries
//  ---------+-----------+-----------------------------------------------------------
//  s_axis   | in        | request: store word, load page or delete page
//  m_axis   | out       | result: status, page, length, payload word; tlast ends item
//
// A store word or a delete is read on acceptance (metadata, free stack and data memory),
// and the execute state then updates them and loads the result. A load passes the same
// states and then emits one payload word per cycle, unless the output stalls, limited
// by the single read port of the page data memory. Request code three is dropped.
// Reset clears the valid map (flip-flops), the counters and the output; the memories
// need no clearing pass. A stalled output holds the block until the result is taken.
module page_store_free_list
    import psfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // page, word_index, byte_count, data_word (from bit 0 up), zero padded
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type, new_page (from bit 0 up), zero padded
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // page_res, byte_length, data_word_res (from bit 0 up), zero padded
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status, zero padded
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast
);

    `include "assert_macros.svh"

    // Control state.
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       free_count_reg, free_count_next;
    logic [CNT_W-1:0]       high_water_reg, high_water_next;
    logic [NUM_PAGES-1:0]   page_valid_reg, page_valid_next;
    logic [PAGE_ID_W-1:0]   cur_page_reg, cur_page_next;
    logic                   store_open_reg, store_open_next;
    logic                   out_valid_reg, out_valid_next;
    logic [WORD_IDX_W-1:0]  k_reg, k_next;

    // Payload state.
    item_t                  item_reg;
    result_t                out_res_reg, out_res_next;
    logic [LEN_W-1:0]       len_reg;
    logic [PAGE_WORDS-1:0]  mask_reg;
    logic [NW_W-1:0]        n_reg;

    // Handshake and unpacked input.
    item_t                  in_item;
    logic                   in_accept;
    logic                   out_free;

    // Memory ports.
    logic                   meta_we;
    logic [PAGE_ID_W-1:0]   meta_waddr, meta_raddr;
    meta_t                  meta_wdata, meta_rd;
    logic                   fs_we;
    logic [PAGE_ID_W-1:0]   fs_waddr, fs_raddr, fs_rd;
    logic                   data_we, data_re;
    logic [DATA_AW-1:0]     data_waddr, data_raddr;
    logic [WORD_W-1:0]      data_rd;

    // Execute-cycle decisions.
    logic                   ex_go;
    logic                   ex_emit;
    logic                   ex_to_load;
    logic                   ex_set_valid;
    logic                   ex_clr_valid;
    logic                   ex_alloc_free;
    logic                   ex_alloc_hw;
    logic                   ex_push;
    logic                   ex_open;
    logic                   ex_close;
    logic [PAGE_ID_W-1:0]   ex_vpage;
    result_t                ex_res;

    // Allocation choice and checks.
    logic                   pick_ok;
    logic                   pick_free;
    logic                   pick_hw;
    logic [PAGE_ID_W-1:0]   pick_page;
    logic [CNT_W-1:0]       fc_dec;
    logic                   valid_page;
    logic                   valid_cur;
    logic                   too_long;
    logic                   widx_over;
    logic [LEN_W:0]         ceil_words;
    logic [NW_W-1:0]        load_words;

    // Load word path.
    logic [LEN_W:0]         ld_rem;
    logic                   ld_partial;
    logic                   ld_last;
    logic                   ld_fire;
    logic [WORD_W-1:0]      ld_word;
    result_t                ld_res;

    // Unpack the input transfer.
    always_comb
    begin
        in_item.req        = s_axis_tuser[REQ_W-1:0];
        in_item.new_page   = s_axis_tuser[REQ_W];
        in_item.page       = s_axis_tdata[PAGE_ID_W-1:0];
        in_item.word_index = s_axis_tdata[WIDX_OFS +: WIDX_W];
        in_item.byte_count = s_axis_tdata[CNT_OFS +: LEN_W];
        in_item.data_word  = s_axis_tdata[DW_OFS +: WORD_W];
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Memory reads are issued on the accept edge and while a load streams out.
    assign fc_dec     = free_count_reg - CNT_W'(1);
    assign fs_raddr   = fc_dec[PAGE_ID_W-1:0];
    assign meta_raddr = (in_item.req == REQ_STORE) ? cur_page_reg : in_item.page;
    assign data_re    = in_accept || (ld_fire && !ld_last);
    assign data_raddr = in_accept ? {in_item.page, WORD_IDX_W'(0)}
                                  : {item_reg.page, k_reg + WORD_IDX_W'(1)};

    // Page checks on the registered request.
    assign valid_page = page_valid_reg[item_reg.page];
    assign valid_cur  = page_valid_reg[cur_page_reg];
    assign too_long   = item_reg.byte_count > LEN_W'(PAGE_BYTES);
    assign widx_over  = {1'b0, item_reg.word_index} >= (WIDX_W + 1)'(PAGE_WORDS);
    assign ceil_words = ({1'b0, meta_rd.len} + (LEN_W + 1)'(7)) >> 3;
    assign load_words = (ceil_words > (LEN_W + 1)'(MAX_WORDS)) ? NW_W'(MAX_WORDS)
                                                               : ceil_words[NW_W-1:0];

    // New page: reuse the most recently freed id, else the next never-used id.
    always_comb
    begin
        pick_ok   = 1'b0;
        pick_free = 1'b0;
        pick_hw   = 1'b0;
        pick_page = item_reg.page;
        if (item_reg.new_page)
        begin
            if (free_count_reg != '0)
            begin
                pick_ok   = 1'b1;
                pick_free = 1'b1;
                pick_page = fs_rd;
            end
            else if (high_water_reg < CNT_W'(NUM_PAGES))
            begin
                pick_ok   = 1'b1;
                pick_hw   = 1'b1;
                pick_page = high_water_reg[PAGE_ID_W-1:0];
            end
        end
        else
        begin
            pick_ok = valid_page;
        end
    end

    // Execute-cycle decode: result, memory writes and table updates of one request.
    always_comb
    begin
        ex_emit       = 1'b1;
        ex_to_load    = 1'b0;
        ex_set_valid  = 1'b0;
        ex_clr_valid  = 1'b0;
        ex_alloc_free = 1'b0;
        ex_alloc_hw   = 1'b0;
        ex_push       = 1'b0;
        ex_open       = 1'b0;
        ex_close      = 1'b0;
        ex_vpage      = item_reg.page;
        meta_we       = 1'b0;
        meta_waddr    = item_reg.page;
        meta_wdata    = meta_rd;
        data_we       = 1'b0;
        data_waddr    = {item_reg.page, WORD_IDX_W'(0)};
        ex_res.status = STAT_OK;
        ex_res.page   = item_reg.page;
        ex_res.len    = '0;
        ex_res.data   = '0;
        ex_res.last   = 1'b1;

        unique case (item_reg.req)
            REQ_STORE:
            begin
                if (item_reg.word_index == '0)
                begin
                    // First word: allocate or check the page, then restart its contents.
                    ex_close   = 1'b1;
                    ex_res.len = item_reg.byte_count;
                    if (too_long)
                    begin
                        ex_res.status = STAT_TOO_LONG;
                        ex_res.page   = item_reg.new_page ? '0 : item_reg.page;
                    end
                    else if (!pick_ok)
                    begin
                        ex_res.status = item_reg.new_page ? STAT_NO_FREE : STAT_BAD_PAGE;
                        ex_res.page   = item_reg.new_page ? '0 : item_reg.page;
                    end
                    else
                    begin
                        ex_alloc_free      = pick_free;
                        ex_alloc_hw        = pick_hw;
                        ex_set_valid       = 1'b1;
                        ex_open            = 1'b1;
                        ex_vpage           = pick_page;
                        ex_res.page        = pick_page;
                        meta_we            = 1'b1;
                        meta_waddr         = pick_page;
                        meta_wdata.len     = item_reg.byte_count;
                        meta_wdata.written = PAGE_WORDS'(1);
                        data_we            = 1'b1;
                        data_waddr         = {pick_page, WORD_IDX_W'(0)};
                    end
                end
                else
                begin
                    // Later word of the open store.
                    ex_res.page = cur_page_reg;
                    if (!store_open_reg || !valid_cur)
                    begin
                        ex_res.status = STAT_BAD_PAGE;
                    end
                    else if (widx_over)
                    begin
                        ex_res.status = STAT_TOO_LONG;
                        ex_res.len    = meta_rd.len;
                    end
                    else
                    begin
                        ex_res.len         = meta_rd.len;
                        meta_we            = 1'b1;
                        meta_waddr         = cur_page_reg;
                        meta_wdata.written = meta_rd.written
                                           | (PAGE_WORDS'(1) << item_reg.word_index);
                        data_we            = 1'b1;
                        data_waddr         = {cur_page_reg,
                                              item_reg.word_index[WORD_IDX_W-1:0]};
                    end
                end
            end
            REQ_LOAD:
            begin
                if (!valid_page)
                begin
                    ex_res.status = STAT_BAD_PAGE;
                end
                else
                begin
                    ex_res.len = meta_rd.len;
                    if (load_words != '0)
                    begin
                        ex_emit    = 1'b0;
                        ex_to_load = 1'b1;
                    end
                end
            end
            REQ_DELETE:
            begin
                if (!valid_page)
                begin
                    ex_res.status = STAT_BAD_PAGE;
                end
                else
                begin
                    ex_clr_valid = 1'b1;
                    ex_push      = free_count_reg < CNT_W'(NUM_PAGES);
                    ex_res.len   = meta_rd.len;
                end
            end
            REQ_NONE:
            begin
                ex_emit = 1'b0;
            end
        endcase
    end

    assign ex_go    = (state_reg == ST_EXEC) && out_free;
    assign fs_we    = ex_go && ex_push;
    assign fs_waddr = free_count_reg[PAGE_ID_W-1:0];

    // Load word: drop bytes past the length and words never written since the store.
    assign ld_rem     = {1'b0, len_reg} - (LEN_W + 1)'({k_reg, 3'b000});
    assign ld_partial = ld_rem < (LEN_W + 1)'(8);
    assign ld_last    = ({1'b0, k_reg} + NW_W'(1)) == n_reg;
    assign ld_fire    = (state_reg == ST_LOAD) && out_free;

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            ld_word[b*8 +: 8] = (mask_reg[k_reg] && (!ld_partial || (3'(b) < ld_rem[2:0])))
                              ? data_rd[b*8 +: 8] : 8'h00;
        end
        ld_res.status = STAT_OK;
        ld_res.page   = item_reg.page;
        ld_res.len    = len_reg;
        ld_res.data   = ld_word;
        ld_res.last   = ld_last;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_item.req != REQ_NONE))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ex_to_load ? ST_LOAD : ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                if (ld_fire && ld_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
    end

    // Table and output updates.
    always_comb
    begin
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        page_valid_next = page_valid_reg;
        cur_page_next   = cur_page_reg;
        store_open_next = store_open_reg;
        k_next          = k_reg;
        out_res_next    = out_res_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        if (ex_go)
        begin
            if (ex_alloc_free)
            begin
                free_count_next = fc_dec;
            end
            if (ex_push)
            begin
                free_count_next = free_count_reg + CNT_W'(1);
            end
            if (ex_alloc_hw)
            begin
                high_water_next = high_water_reg + CNT_W'(1);
            end
            if (ex_set_valid)
            begin
                page_valid_next[ex_vpage] = 1'b1;
            end
            if (ex_clr_valid)
            begin
                page_valid_next[item_reg.page] = 1'b0;
            end
            if (ex_close)
            begin
                store_open_next = ex_open;
            end
            if (ex_open)
            begin
                cur_page_next = ex_vpage;
            end
            if (ex_emit)
            begin
                out_res_next   = ex_res;
                out_valid_next = 1'b1;
            end
            if (ex_to_load)
            begin
                k_next = '0;
            end
        end

        if (ld_fire)
        begin
            out_res_next   = ld_res;
            out_valid_next = 1'b1;
            k_next         = k_reg + WORD_IDX_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_count_reg <= '0;
            high_water_reg <= '0;
            page_valid_reg <= '0;
            cur_page_reg   <= '0;
            store_open_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            page_valid_reg <= page_valid_next;
            cur_page_reg   <= cur_page_next;
            store_open_reg <= store_open_next;
            out_valid_reg  <= out_valid_next;
            k_reg          <= k_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        if (in_accept)
        begin
            item_reg <= in_item;
        end
        if ((state_reg == ST_EXEC) && ex_to_load)
        begin
            len_reg  <= meta_rd.len;
            mask_reg <= meta_rd.written;
            n_reg    <= load_words;
        end
    end

    // Output transfer.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res_reg.data, out_res_reg.len,
                            out_res_reg.page};
    assign m_axis_tuser  = OUT_USER_W'(out_res_reg.status);
    assign m_axis_tlast  = out_res_reg.last;

    // Page length and written-word mask.
    psfl_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_PAGES)
    ) u_meta_ram (
        .clk     (clk),
        .we      (meta_we && ex_go),
        .waddr   (meta_waddr),
        .wdata   (meta_wdata),
        .re      (in_accept),
        .raddr   (meta_raddr),
        .rd_data (meta_rd)
    );

    // Free-page stack.
    psfl_ram #(
        .WIDTH (PAGE_ID_W),
        .DEPTH (NUM_PAGES)
    ) u_free_ram (
        .clk     (clk),
        .we      (fs_we),
        .waddr   (fs_waddr),
        .wdata   (item_reg.page),
        .re      (in_accept),
        .raddr   (fs_raddr),
        .rd_data (fs_rd)
    );

    // Page payload words.
    psfl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .we      (data_we && ex_go),
        .waddr   (data_waddr),
        .wdata   (item_reg.data_word),
        .re      (data_re),
        .raddr   (data_raddr),
        .rd_data (data_rd)
    );

    // Every freed id was handed out before, so the stack never outgrows the used ids.
    `PSFL_ASSERT(a_free_le_high, free_count_reg <= high_water_reg, "free stack exceeds used ids")
    `PSFL_ASSERT(a_high_bound, high_water_reg <= CNT_W'(NUM_PAGES), "high water past page count")
    // A newly allocated page is never one that is still valid.
    `PSFL_ASSERT(a_alloc_free_page, (ex_go && (ex_alloc_free || ex_alloc_hw)) |-> !page_valid_reg[ex_vpage], "allocated a valid page")
    // The load word counter stays inside the page being streamed.
    `PSFL_ASSERT(a_load_count, (state_reg == ST_LOAD) |-> ({1'b0, k_reg} < n_reg), "load word past end")

endmodule

/* tb/sv/tb_page_store_free_list.sv */
// Self-checking testbench for the page store with a last-in first-out free-page stack.
module tb_page_store_free_list;
    import psfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 40;

    // One row of the directed table, with an optional typed-in single result.
    typedef struct {
        item_t   it;
        bit      typed;
        result_t given;
    } table_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    // Predictor copy of the block state.
    bit                    page_valid [NUM_PAGES];
    logic [PAGE_ID_W-1:0]  free_ids [NUM_PAGES];
    int                    free_count;
    int                    high_water;
    logic [LEN_W-1:0]      page_len [NUM_PAGES];
    logic [WORD_W-1:0]     page_mem [NUM_PAGES*PAGE_WORDS];
    logic [PAGE_ID_W-1:0]  cur_page;
    bit                    store_open;

    result_t               step_results [$];
    result_t               due_results [$];
    table_row_t            directed_rows [$];

    int                    burst_left;
    int                    items_sent;
    int                    failures;
    int                    n_results;
    int                    n_status [4];
    int                    n_req [4];
    int                    cycles;
    int                    ready_hold;
    logic [15:0]           ready_mask;

    page_store_free_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver stalls on a rotating mask that is reloaded now and then; some masks
    // never stall.
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_hold = $urandom_range(16, 96);
            ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
        end
        ready_hold--;
        ready_mask = {ready_mask[14:0], ready_mask[15]};
        m_axis_tready <= ready_mask[0];
    end

    // Appends one row to the directed table.
    function automatic void add_row(input table_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Works out the results of one request and updates the predicted state.
    function automatic void run_page_request(input item_t it);
        result_t              r;
        logic [PAGE_ID_W-1:0] p;
        int                   len;
        int                   nwords;
        int                   rem;
        logic [WORD_W-1:0]    w;
        step_results.delete();
        r = '0;
        r.last = 1'b1;
        case (it.req)
            REQ_STORE:
            begin
                if (it.word_index == 0)
                begin
                    store_open = 1'b0;
                    r.len = it.byte_count;
                    if (int'(it.byte_count) > PAGE_BYTES)
                    begin
                        r.status = STAT_TOO_LONG;
                        r.page = it.new_page ? '0 : it.page;
                    end
                    else if (it.new_page && free_count == 0 && high_water >= NUM_PAGES)
                    begin
                        r.status = STAT_NO_FREE;
                        r.page = '0;
                    end
                    else if (!it.new_page && !page_valid[it.page])
                    begin
                        r.status = STAT_BAD_PAGE;
                        r.page = it.page;
                    end
                    else
                    begin
                        if (!it.new_page)
                            p = it.page;
                        else if (free_count > 0)
                        begin
                            free_count--;
                            p = free_ids[free_count];
                        end
                        else
                        begin
                            p = PAGE_ID_W'(high_water);
                            high_water++;
                        end
                        // A new store clears the whole page before word 0 lands.
                        page_valid[p] = 1'b1;
                        page_len[p] = it.byte_count;
                        for (int k = 0; k < PAGE_WORDS; k++)
                            page_mem[p*PAGE_WORDS + k] = '0;
                        page_mem[p*PAGE_WORDS] = it.data_word;
                        cur_page = p;
                        store_open = 1'b1;
                        r.status = STAT_OK;
                        r.page = p;
                    end
                end
                else if (!store_open || !page_valid[cur_page])
                begin
                    r.status = STAT_BAD_PAGE;
                    r.page = cur_page;
                end
                else if (int'(it.word_index) >= PAGE_WORDS)
                begin
                    r.status = STAT_TOO_LONG;
                    r.page = cur_page;
                    r.len = page_len[cur_page];
                end
                else
                begin
                    page_mem[cur_page*PAGE_WORDS + it.word_index] = it.data_word;
                    r.status = STAT_OK;
                    r.page = cur_page;
                    r.len = page_len[cur_page];
                end
                step_results.insert(step_results.size(), r);
            end
            REQ_LOAD:
            begin
                r.page = it.page;
                if (!page_valid[it.page])
                begin
                    r.status = STAT_BAD_PAGE;
                    step_results.insert(step_results.size(), r);
                end
                else
                begin
                    len = page_len[it.page];
                    nwords = (len + 7) / 8;
                    if (nwords > MAX_WORDS)
                        nwords = MAX_WORDS;
                    r.status = STAT_OK;
                    r.len = LEN_W'(len);
                    if (nwords == 0)
                        step_results.insert(step_results.size(), r);
                    // One result per payload word; bytes past the length read as zero.
                    for (int k = 0; k < nwords; k++)
                    begin
                        w = page_mem[it.page*PAGE_WORDS + k];
                        rem = len - k*8;
                        if (rem < 8)
                            w &= (64'd1 << (rem*8)) - 64'd1;
                        r.data = w;
                        r.last = (k + 1 == nwords);
                        step_results.insert(step_results.size(), r);
                    end
                end
            end
            REQ_DELETE:
            begin
                r.page = it.page;
                if (!page_valid[it.page])
                    r.status = STAT_BAD_PAGE;
                else
                begin
                    page_valid[it.page] = 1'b0;
                    if (free_count < NUM_PAGES)
                    begin
                        free_ids[free_count] = it.page;
                        free_count++;
                    end
                    r.status = STAT_OK;
                    r.len = page_len[it.page];
                end
                step_results.insert(step_results.size(), r);
            end
            default:
            begin
                // Request code three is dropped without a result.
            end
        endcase
    endfunction

    // Drives one request, waits for its transfer and records what it should produce.
    task automatic send_request(input item_t it, input bit typed, input result_t given);
        logic [IN_DATA_W-1:0] d;
        logic [IN_USER_W-1:0] u;
        int                   gap;
        bit                   taken;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        d = '0;
        d[0 +: PAGE_ID_W] = it.page;
        d[WIDX_OFS +: WIDX_W] = it.word_index;
        d[CNT_OFS +: LEN_W] = it.byte_count;
        d[DW_OFS +: WORD_W] = it.data_word;
        u = '0;
        u[0 +: REQ_W] = it.req;
        u[REQ_W] = it.new_page;
        s_axis_tdata <= d;
        s_axis_tuser <= u;
        s_axis_tvalid <= 1'b1;
        // Handshake is judged mid-cycle, where every signal is settled.
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_axis_tvalid && s_axis_tready;
            @(posedge clk);
        end
        run_page_request(it);
        if (typed)
            due_results.insert(due_results.size(), given);
        else
            foreach (step_results[i])
                due_results.insert(due_results.size(), step_results[i]);
        n_req[it.req]++;
        if (it.req != REQ_NONE)
            items_sent++;
    endtask

    task automatic send_plain(input item_t it);
        send_request(it, 1'b0, '0);
    endtask

    // Holds the sender off until every expected result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return LEN_W'($urandom_range(PAGE_BYTES + 1, 511));
        if (r < 20)
            return LEN_W'($urandom_range(PAGE_BYTES - 56, PAGE_BYTES));
        return LEN_W'($urandom_range(0, 64));
    endfunction

    // Prefers a page that is live in the predictor, falling back to the last id it tried.
    function automatic logic [PAGE_ID_W-1:0] pick_page();
        logic [PAGE_ID_W-1:0] p;
        p = PAGE_ID_W'($urandom);
        if (high_water > 0)
            for (int t = 0; t < 8; t++)
            begin
                p = PAGE_ID_W'($urandom_range(0, high_water - 1));
                if (page_valid[p])
                    return p;
            end
        return p;
    endfunction

    function automatic item_t mk_item(req_code_t req, bit newp, logic [PAGE_ID_W-1:0] pg,
                                      logic [WIDX_W-1:0] wi, logic [LEN_W-1:0] cnt,
                                      logic [WORD_W-1:0] dw);
        item_t it;
        it.req = req;
        it.new_page = newp;
        it.page = pg;
        it.word_index = wi;
        it.byte_count = cnt;
        it.data_word = dw;
        return it;
    endfunction

    function automatic table_row_t mk_row(item_t it, bit typed, status_t st,
                                          logic [PAGE_ID_W-1:0] rpg, logic [LEN_W-1:0] rlen);
        table_row_t row;
        row.it = it;
        row.typed = typed;
        row.given = '0;
        row.given.status = st;
        row.given.page = rpg;
        row.given.len = rlen;
        row.given.last = 1'b1;
        return row;
    endfunction

    // Random mix: mostly store runs with random content, plus loads, deletes and noise.
    task automatic run_mix(input int count);
        int                   target;
        int                   choice;
        int                   nwords;
        int                   extra;
        logic [LEN_W-1:0]     cnt;
        logic [PAGE_ID_W-1:0] pg;
        bit                   newp;
        logic [WIDX_W-1:0]    wi;
        target = items_sent + count;
        while (items_sent < target)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 45)
            begin
                newp = ($urandom_range(0, 3) != 0);
                pg = newp ? PAGE_ID_W'($urandom) : pick_page();
                cnt = pick_len();
                send_plain(mk_item(REQ_STORE, newp, pg, '0, cnt, {$urandom, $urandom}));
                nwords = (int'(cnt) + 7) / 8;
                extra = $urandom_range(0, 4);
                for (int j = 0; j < extra; j++)
                begin
                    if (nwords <= 1 || $urandom_range(0, 7) == 0)
                        wi = WIDX_W'($urandom_range(1, 31));
                    else
                        wi = WIDX_W'($urandom_range(1, (nwords > 32 ? 32 : nwords) - 1));
                    // Now and then the open page disappears under the run.
                    if ($urandom_range(0, 19) == 0)
                        send_plain(mk_item(REQ_DELETE, 1'b0, cur_page, '0, '0, '0));
                    send_plain(mk_item(REQ_STORE, 1'b0, PAGE_ID_W'($urandom), wi,
                                       LEN_W'($urandom), {$urandom, $urandom}));
                end
                if ($urandom_range(0, 1) == 0)
                    send_plain(mk_item(REQ_LOAD, 1'b0, cur_page, '0, '0, '0));
            end
            else if (choice < 65)
                send_plain(mk_item(REQ_LOAD, 1'b0, pick_page(), WIDX_W'($urandom),
                                   LEN_W'($urandom), {$urandom, $urandom}));
            else if (choice < 80)
                send_plain(mk_item(REQ_DELETE, 1'b0, pick_page(), WIDX_W'($urandom),
                                   LEN_W'($urandom), {$urandom, $urandom}));
            else
                send_plain(mk_item(req_code_t'($urandom_range(0, 3)), 1'($urandom),
                                   PAGE_ID_W'($urandom), WIDX_W'($urandom), pick_len(),
                                   {$urandom, $urandom}));
        end
    endtask

    // Result checker: each transfer is compared with the oldest expectation.
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            n_status[m_axis_tuser[0 +: STATUS_W]]++;
            if (due_results.size() == 0)
            begin
                $error("result transfer with no expectation pending: tdata %h", m_axis_tdata);
                failures++;
            end
            else
            begin
                want = due_results.pop_front();
                if (m_axis_tuser[0 +: STATUS_W] !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status,
                           m_axis_tuser[0 +: STATUS_W]);
                    failures++;
                end
                if (m_axis_tdata[0 +: PAGE_ID_W] !== want.page)
                begin
                    $error("page_res: expected %0d, actual %0d", want.page,
                           m_axis_tdata[0 +: PAGE_ID_W]);
                    failures++;
                end
                if (m_axis_tdata[PAGE_ID_W +: LEN_W] !== want.len)
                begin
                    $error("byte_length: expected %0d, actual %0d", want.len,
                           m_axis_tdata[PAGE_ID_W +: LEN_W]);
                    failures++;
                end
                if (m_axis_tdata[PAGE_ID_W + LEN_W +: WORD_W] !== want.data)
                begin
                    $error("data_word_res: expected %h, actual %h", want.data,
                           m_axis_tdata[PAGE_ID_W + LEN_W +: WORD_W]);
                    failures++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
                    failures++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        logic [WORD_W-1:0] ones;
        int                n_drop;
        ones = '1;

        // Directed table: empty store, limits, reuse order and the bad-page and too-long errors.
        add_row(mk_row(mk_item(REQ_LOAD, 1'b0, 8'd0, '0, '0, '0),
                       1'b1, STAT_BAD_PAGE, 8'd0, '0));
        add_row(mk_row(mk_item(REQ_DELETE, 1'b0, 8'd255, '0, '0, '0),
                       1'b1, STAT_BAD_PAGE, 8'd255, '0));
        add_row(mk_row(mk_item(REQ_STORE, 1'b0, 8'd0, 5'd1, '0, ones),
                       1'b1, STAT_BAD_PAGE, 8'd0, '0));
        add_row(mk_row(mk_item(REQ_STORE, 1'b1, 8'd0, '0, 9'd257, ones),
                       1'b1, STAT_TOO_LONG, 8'd0, 9'd257));
        add_row(mk_row(mk_item(REQ_STORE, 1'b0, 8'd255, '0, 9'd8, ones),
                       1'b1, STAT_BAD_PAGE, 8'd255, 9'd8));
        add_row(mk_row(mk_item(REQ_STORE, 1'b1, 8'd0, '0, 9'd256, ones),
                       1'b1, STAT_OK, 8'd0, 9'd256));
        add_row(mk_row(mk_item(REQ_STORE, 1'b0, 8'd0, 5'd31, '0,
                               64'hA5A5_5A5A_F00F_0FF0), 1'b0, STAT_OK, '0, '0));
        add_row(mk_row(mk_item(REQ_STORE, 1'b0, 8'd0, 5'd1, '0,
                               64'h0123_4567_89AB_CDEF), 1'b0, STAT_OK, '0, '0));
        add_row(mk_row(mk_item(REQ_LOAD, 1'b0, 8'd0, '0, '0, '0),
                       1'b0, STAT_OK, '0, '0));
        add_row(mk_row(mk_item(REQ_STORE, 1'b1, 8'd0, '0, 9'd0, ones),
                       1'b1, STAT_OK, 8'd1, 9'd0));
        add_row(mk_row(mk_item(REQ_LOAD, 1'b0, 8'd1, '0, '0, '0),
                       1'b1, STAT_OK, 8'd1, 9'd0));
        add_row(mk_row(mk_item(REQ_STORE, 1'b1, 8'd0, '0, 9'd13, ones),
                       1'b1, STAT_OK, 8'd2, 9'd13));
        add_row(mk_row(mk_item(REQ_STORE, 1'b0, 8'd0, 5'd1, '0, ones),
                       1'b0, STAT_OK, '0, '0));
        add_row(mk_row(mk_item(REQ_LOAD, 1'b0, 8'd2, '0, '0, '0),
                       1'b0, STAT_OK, '0, '0));
        add_row(mk_row(mk_item(REQ_DELETE, 1'b0, 8'd0, '0, '0, '0),
                       1'b1, STAT_OK, 8'd0, 9'd256));
        add_row(mk_row(mk_item(REQ_STORE, 1'b1, 8'd77, '0, 9'd40,
                               64'h8000_0000_0000_0001), 1'b1, STAT_OK, 8'd0, 9'd40));
        add_row(mk_row(mk_item(REQ_DELETE, 1'b0, 8'd0, '0, '0, '0),
                       1'b1, STAT_OK, 8'd0, 9'd40));
        add_row(mk_row(mk_item(REQ_STORE, 1'b0, 8'd0, 5'd5, '0, ones),
                       1'b1, STAT_BAD_PAGE, 8'd0, '0));
        add_row(mk_row(mk_item(REQ_NONE, 1'b1, 8'd255, 5'd31, 9'd511, ones),
                       1'b0, STAT_OK, '0, '0));
        add_row(mk_row(mk_item(REQ_STORE, 1'b0, 8'd2, '0, 9'd40,
                               64'hDEAD_BEEF_CAFE_F00D), 1'b1, STAT_OK, 8'd2, 9'd40));
        add_row(mk_row(mk_item(REQ_STORE, 1'b0, 8'd7, '0, 9'd511, ones),
                       1'b1, STAT_TOO_LONG, 8'd7, 9'd511));
        add_row(mk_row(mk_item(REQ_STORE, 1'b0, 8'd0, 5'd1, '0, ones),
                       1'b1, STAT_BAD_PAGE, 8'd2, '0));
        add_row(mk_row(mk_item(REQ_LOAD, 1'b0, 8'd2, '0, '0, '0),
                       1'b0, STAT_OK, '0, '0));
        add_row(mk_row(mk_item(REQ_STORE, 1'b1, 8'd255, '0, 9'd256, '0),
                       1'b0, STAT_OK, '0, '0));

        // Reset once, at the start.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].given);

        run_mix(30);
        drain_results();

        // Fill every page, then ask for more to hit the exhausted store.
        while (!(free_count == 0 && high_water >= NUM_PAGES))
            send_plain(mk_item(REQ_STORE, 1'b1, PAGE_ID_W'($urandom), '0,
                               LEN_W'($urandom_range(0, 24)), {$urandom, $urandom}));
        repeat (3)
            send_plain(mk_item(REQ_STORE, 1'b1, PAGE_ID_W'($urandom), '0,
                               LEN_W'($urandom_range(0, PAGE_BYTES)), {$urandom, $urandom}));

        // Free a random share of the pages so the stack refills in random order.
        n_drop = $urandom_range(8, 16);
        repeat (n_drop)
            send_plain(mk_item(REQ_DELETE, 1'b0, PAGE_ID_W'($urandom), '0, '0, '0));

        run_mix(25);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (due_results.size() != 0)
        begin
            $error("%0d expected results never arrived", due_results.size());
            failures++;
        end
        $display("Sent %0d requests (%0d store, %0d load, %0d delete, %0d dropped code).",
                 items_sent + n_req[REQ_NONE], n_req[REQ_STORE], n_req[REQ_LOAD],
                 n_req[REQ_DELETE], n_req[REQ_NONE]);
        $display("Checked %0d results: %0d ok, %0d bad page, %0d store full, %0d too long.",
                 n_results, n_status[STAT_OK], n_status[STAT_BAD_PAGE],
                 n_status[STAT_NO_FREE], n_status[STAT_TOO_LONG]);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
